@@ rtl/rsae_pkg.sv @@
package rsae_pkg;

  localparam int unsigned STATE_W   = 20;
  localparam int unsigned ROW_W     = 4;
  localparam int unsigned NUM_ROWS  = 5;
  localparam int unsigned KEY_W     = 4;
  localparam int unsigned BLOCK_W   = 4;
  localparam int unsigned OP_W      = 3;
  localparam int unsigned NBITS_W   = 2;
  localparam int unsigned CBITS_W   = 3;

  localparam int unsigned ROUNDS_INIT_DEF  = 4;
  localparam int unsigned ROUNDS_BLOCK_DEF = 2;

  typedef logic [STATE_W-1:0] state_t;

  typedef enum logic [OP_W-1:0] {
    OP_START     = 3'd0,
    OP_ASSOC     = 3'd1,
    OP_ASSOC_END = 3'd2,
    OP_PLAIN     = 3'd3,
    OP_PLAIN_END = 3'd4
  } op_t;

  localparam logic [4:0] SBOX [32] = '{
    5'h04, 5'h0b, 5'h1f, 5'h14, 5'h1a, 5'h15, 5'h09, 5'h02,
    5'h1b, 5'h05, 5'h08, 5'h12, 5'h1d, 5'h03, 5'h06, 5'h1c,
    5'h1e, 5'h13, 5'h07, 5'h0e, 5'h00, 5'h0d, 5'h11, 5'h18,
    5'h10, 5'h0c, 5'h01, 5'h19, 5'h16, 5'h0a, 5'h0f, 5'h17
  };

  localparam logic [ROW_W-1:0] ROUND_CONST [4] = '{4'h4, 4'h2, 4'hA, 4'h8};

  // Diffusion rotation amounts, already reduced mod 4 (19,28 61,39 1,6 10,17 7,41)
  localparam logic [1:0] ROT_P [NUM_ROWS] = '{2'd3, 2'd1, 2'd1, 2'd2, 2'd3};
  localparam logic [1:0] ROT_Q [NUM_ROWS] = '{2'd0, 2'd3, 2'd2, 2'd1, 2'd1};

  function automatic logic [ROW_W-1:0] rotr4(input logic [ROW_W-1:0] x,
                                             input logic [1:0] n);
    logic [2*ROW_W-1:0] dbl;
    dbl = {x, x} >> n;
    return dbl[ROW_W-1:0];
  endfunction

  function automatic state_t one_round(input state_t s, input logic [ROW_W-1:0] rc);
    logic [ROW_W-1:0] row [NUM_ROWS];
    logic [ROW_W-1:0] sub [NUM_ROWS];
    logic [4:0]       col;
    logic [4:0]       y;
    state_t           res;
    for (int i = 0; i < NUM_ROWS; i++) begin
      row[i] = s[STATE_W-1-ROW_W*i -: ROW_W];
      sub[i] = '0;
    end
    row[2] = row[2] ^ rc;
    for (int j = 0; j < ROW_W; j++) begin
      for (int i = 0; i < NUM_ROWS; i++) begin
        col[4-i] = row[i][ROW_W-1-j];
      end
      y = SBOX[col];
      for (int i = 0; i < NUM_ROWS; i++) begin
        sub[i][ROW_W-1-j] = y[4-i];
      end
    end
    res = '0;
    for (int i = 0; i < NUM_ROWS; i++) begin
      res[STATE_W-1-ROW_W*i -: ROW_W] = sub[i] ^ rotr4(sub[i], ROT_P[i])
                                        ^ rotr4(sub[i], ROT_Q[i]);
    end
    return res;
  endfunction

endpackage

@@ rtl/reduced_sponge_aead_encrypt_unit.sv @@
// Reduced sponge AEAD encryption on a 20-bit state (five 4-bit rows, 4-bit rate).
// Send one request per operation on the s_ side: start, associated-data block,
// end of associated data, plaintext block, last plaintext block. Plaintext and
// last-block requests each return one result on the m_ side; the others return
// nothing. The unit takes one request every cycle unless stalled; a request is held
// in an input register, worked off in a single pass (up to ROUNDS_INIT unrolled
// rounds) and its result is registered in the output register. The sponge state
// is updated in the same pass, so back-to-back requests chain correctly. A result
// that waits in the output register stalls the input register only when that one
// also holds a request that yields a result. The user must write the key through
// cfg_wr_en / cfg_wr_data while the unit is idle; the unit does not enforce this.
module reduced_sponge_aead_encrypt_unit
  import rsae_pkg::*;
#(
  parameter int unsigned ROUNDS_INIT  = ROUNDS_INIT_DEF,
  parameter int unsigned ROUNDS_BLOCK = ROUNDS_BLOCK_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [KEY_W-1:0] cfg_wr_data,  // secret_key
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [15:0]      s_tdata,      // nonce[3:0], data_block[7:4], last_bits[9:8]
  input  logic [OP_W-1:0]  s_tuser,      // op[2:0]
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [15:0]      m_tdata,      // cipher_block[3:0], cipher_bits[6:4], auth_tag[10:7]
  output logic             m_tuser       // tag_valid[0]
);

  // Initialization vector: kind and round counts in the upper row bits
  localparam logic [11:0] IV = 12'((4 << 9) | (4 << 6) | ((ROUNDS_INIT % 8) << 3)
                                   | (ROUNDS_BLOCK % 8));

  logic [KEY_W-1:0]   secret_key;
  state_t             sponge_state;
  state_t             sponge_state_next;

  // Input register
  logic               in_valid;
  logic [OP_W-1:0]    hold_op;
  logic [ROW_W-1:0]   hold_nonce;
  logic [BLOCK_W-1:0] hold_data;
  logic [NBITS_W-1:0] hold_bits;

  // Output register
  logic               out_valid;
  logic [BLOCK_W-1:0] out_cipher;
  logic [CBITS_W-1:0] out_cbits;
  logic [KEY_W-1:0]   out_tag;
  logic               out_tag_valid;

  state_t             init_in, init_out, blk_in, blk_out;
  logic               has_result;
  logic               advance;
  logic [BLOCK_W-1:0] rate, keep, padded, cipher;
  logic [BLOCK_W-1:0] res_cipher;
  logic [CBITS_W-1:0] res_cbits;
  logic [KEY_W-1:0]   res_tag;
  logic               res_tag_valid;

  rsae_permute #(.ROUNDS(ROUNDS_INIT)) u_perm_init (
    .state_in  (init_in),
    .state_out (init_out)
  );

  rsae_permute #(.ROUNDS(ROUNDS_BLOCK)) u_perm_block (
    .state_in  (blk_in),
    .state_out (blk_out)
  );

  assign rate = sponge_state[STATE_W-1 -: ROW_W];

  // Leading last_bits bits survive; pad the rest with zeros and a final one
  always_comb begin
    unique case (hold_bits)
      2'd0:    keep = 4'b0000;
      2'd1:    keep = 4'b1000;
      2'd2:    keep = 4'b1100;
      default: keep = 4'b1110;
    endcase
  end
  assign padded = (hold_data & keep) | 4'b0001;

  always_comb begin
    init_in           = '0;
    blk_in            = '0;
    sponge_state_next = sponge_state;
    has_result        = 1'b0;
    cipher            = '0;
    res_cipher        = '0;
    res_cbits         = '0;
    res_tag           = '0;
    res_tag_valid     = 1'b0;
    unique case (op_t'(hold_op))
      OP_START: begin
        init_in           = {IV, secret_key, hold_nonce};
        sponge_state_next = init_out ^ {16'h0000, secret_key};
      end
      OP_ASSOC: begin
        blk_in            = sponge_state ^ {hold_data, 16'h0000};
        sponge_state_next = blk_out;
      end
      OP_ASSOC_END: begin
        sponge_state_next = sponge_state ^ 20'h00001;
      end
      OP_PLAIN: begin
        cipher            = rate ^ hold_data;
        blk_in            = {cipher, sponge_state[15:0]};
        sponge_state_next = blk_out;
        has_result        = 1'b1;
        res_cipher        = cipher;
        res_cbits         = CBITS_W'(BLOCK_W);
      end
      OP_PLAIN_END: begin
        cipher            = rate ^ padded;
        init_in           = {cipher, sponge_state[15:0]} ^ {4'h0, secret_key, 12'h000};
        sponge_state_next = init_out;
        has_result        = 1'b1;
        res_cipher        = cipher & keep;
        res_cbits         = {1'b0, hold_bits};
        res_tag           = init_out[KEY_W-1:0] ^ secret_key;
        res_tag_valid     = 1'b1;
      end
      default: begin
        // unused codes: drop, state untouched
      end
    endcase
  end

  // Advance the held request unless its result would land on a stalled one
  assign advance  = in_valid && (!has_result || !out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      secret_key <= '0;
    end else if (cfg_wr_en) begin
      secret_key <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sponge_state <= '0;
      in_valid     <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (advance) begin
        sponge_state <= sponge_state_next;
      end
      if (s_tvalid && s_tready) begin
        in_valid <= 1'b1;
      end else if (advance) begin
        in_valid <= 1'b0;
      end
      if (advance && has_result) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers: no reset needed
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      hold_op    <= s_tuser;
      hold_nonce <= s_tdata[3:0];
      hold_data  <= s_tdata[7:4];
      hold_bits  <= s_tdata[9:8];
    end
    if (advance && has_result) begin
      out_cipher    <= res_cipher;
      out_cbits     <= res_cbits;
      out_tag       <= res_tag;
      out_tag_valid <= res_tag_valid;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {5'b00000, out_tag, out_cbits, out_cipher};
  assign m_tuser  = out_tag_valid;

`ifndef SYNTHESIS
  a_reset_clears: assert property (@(posedge clk)
    rst |=> (sponge_state == '0) && !in_valid && !out_valid && (secret_key == '0))
    else $error("reset did not clear state and valids");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    advance && has_result |=> out_valid)
    else $error("result of a block request was lost");

  a_full_block_fields: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> (m_tdata[6:4] == 3'd4) && (m_tdata[10:7] == 4'h0))
    else $error("full block result with wrong bit count or tag");

  a_last_block_bits: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> !m_tdata[6])
    else $error("last block reports more than three valid bits");
`endif

endmodule

@@ rtl/rsae_permute.sv @@
module rsae_permute
  import rsae_pkg::*;
#(
  parameter int unsigned ROUNDS = ROUNDS_INIT_DEF
) (
  input  state_t state_in,
  output state_t state_out
);

  state_t chain [ROUNDS+1];

  assign chain[0] = state_in;

  // Late rounds of the constant table: round i uses constant i + 4 - ROUNDS
  for (genvar i = 0; i < ROUNDS; i++) begin : g_round
    localparam logic [1:0] RC_IDX = 2'((i + 4 - ROUNDS) % 4);
    assign chain[i+1] = one_round(chain[i], ROUND_CONST[RC_IDX]);
  end

  assign state_out = chain[ROUNDS];

endmodule
